### rtl/wns_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wns_pkg: shared types and constants of the wavetable note synthesiser
// Command codes, register indexes, table sizes, the pitch step table and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package wns_pkg;

    localparam int WAVE_DEPTH  = 256;
    localparam int ENV_DEPTH   = 64;
    localparam int NOTE_COUNT  = 24;
    localparam int OCT_NOTES   = 12;

    localparam int WAVE_AW     = $clog2(WAVE_DEPTH);
    localparam int ENV_AW      = $clog2(ENV_DEPTH);
    localparam int SAMPLE_W    = 8;
    localparam int PHASE_W     = 16;
    localparam int COUNT_W     = 16;
    localparam int OCTAVE_W    = 8;
    localparam int NOTE_W      = 5;
    localparam int PITCH_W     = 12;
    localparam int STEP_PROD_W = OCTAVE_W + PITCH_W;

    localparam int CMD_W       = 2;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int DIV_STEPS   = ENV_AW;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [NOTE_W-1:0] NOTE_LAST  = NOTE_W'(NOTE_COUNT - 1);
    localparam logic [NOTE_W-1:0] NOTE_OCTUP = NOTE_W'(OCT_NOTES);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_WAVE = 2'd0,
        CMD_LOAD_ENV  = 2'd1,
        CMD_START     = 2'd2,
        CMD_EMIT      = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OCTAVE_MULT  = 1'd0,
        REG_SAMPLE_COUNT = 1'd1
    } t_reg;

    typedef struct packed {
        logic wave_we;
        logic env_we;
        logic note_start;
        logic div_init;
        logic div_step;
        logic mem_rd;
        logic mul_en;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

    function automatic logic [PITCH_W-1:0] pitch_step(input logic [3:0] idx);
        logic [PITCH_W-1:0] step;
        case (idx)
            4'd0:    step = 12'd1551;
            4'd1:    step = 12'd1652;
            4'd2:    step = 12'd1747;
            4'd3:    step = 12'd1848;
            4'd4:    step = 12'd1955;
            4'd5:    step = 12'd2074;
            4'd6:    step = 12'd2205;
            4'd7:    step = 12'd2324;
            4'd8:    step = 12'd2461;
            4'd9:    step = 12'd2616;
            4'd10:   step = 12'd2770;
            4'd11:   step = 12'd2938;
            default: step = 12'd0;
        endcase
        return step;
    endfunction

endpackage : wns_pkg
`default_nettype wire

### rtl/wns_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wns_ram: generic single-clock RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule : wns_ram
`default_nettype wire

### rtl/wns_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wns_ctrl: command sequencer of the wavetable note synthesiser
// Accepts requests, decodes loads and note starts, and steps an emit request
// through the envelope divider, the table read, the multiply and the output.
// ----------------------------------------------------------------------------
module wns_ctrl (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    input  wire logic [wns_pkg::CMD_W-1:0] i_cmd,
    output logic                          o_ready,
    output wns_pkg::t_dp_cmd              o_dp_cmd,
    input  wire wns_pkg::t_dp_sts         i_dp_sts
);
    import wns_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_MUL,
        ST_OUT
    } t_state;

    t_state               r_state;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 w_accept;
    t_cmd                 w_cmd;

    assign w_cmd    = t_cmd'(i_cmd);
    assign o_ready  = i_rst_n && (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (w_accept && w_cmd == CMD_EMIT) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= ST_READ;
                    end
                end
                ST_READ: r_state <= ST_MUL;
                ST_MUL:  r_state <= ST_OUT;
                ST_OUT: begin
                    if (i_dp_sts.out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        o_dp_cmd            = '0;
        o_dp_cmd.wave_we    = w_accept && w_cmd == CMD_LOAD_WAVE;
        o_dp_cmd.env_we     = w_accept && w_cmd == CMD_LOAD_ENV;
        o_dp_cmd.note_start = w_accept && w_cmd == CMD_START;
        o_dp_cmd.div_init   = w_accept && w_cmd == CMD_EMIT;
        o_dp_cmd.div_step   = (r_state == ST_DIV);
        o_dp_cmd.mem_rd     = (r_state == ST_READ);
        o_dp_cmd.mul_en     = (r_state == ST_MUL);
        o_dp_cmd.out_load   = (r_state == ST_OUT) && i_dp_sts.out_free;
    end

endmodule : wns_ctrl
`default_nettype wire

### rtl/wns_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wns_dpath: datapath of the wavetable note synthesiser
// Holds the configuration, the note state, both tables, the envelope index
// divider, the sample multiplier and the output register.
// ----------------------------------------------------------------------------
module wns_dpath (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [wns_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [wns_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic [20:0]                      i_in_data,
    input  wire wns_pkg::t_dp_cmd                 i_dp_cmd,
    output wns_pkg::t_dp_sts                      o_dp_sts,
    input  wire logic                             i_out_ready,
    output logic                                  o_out_valid,
    output logic [wns_pkg::SAMPLE_W-1:0]          o_sample,
    output logic                                  o_last
);
    import wns_pkg::*;

    logic [OCTAVE_W-1:0]    r_octave;
    logic [COUNT_W-1:0]     r_count;
    logic [PHASE_W-1:0]     r_phase;
    logic [COUNT_W-1:0]     r_pos;
    logic [NOTE_W-1:0]      r_note;
    logic [STEP_PROD_W-1:0] r_step_prod;
    logic [COUNT_W-1:0]     r_rem;
    logic [ENV_AW-1:0]      r_quo;
    logic                   r_sat;
    logic                   r_last;
    logic signed [16:0]     r_prod;
    logic                   r_out_valid;
    logic [SAMPLE_W-1:0]    r_sample;
    logic                   r_out_last;

    logic [COUNT_W-1:0]     w_count_eff;
    logic [COUNT_W:0]       w_rem2;
    logic [COUNT_W:0]       w_diff;
    logic                   w_ge;
    logic [ENV_AW-1:0]      w_env_idx;
    logic [NOTE_W-1:0]      w_in_note;
    logic [3:0]             w_pidx;
    logic [STEP_PROD_W-1:0] w_step_prod;
    logic [PHASE_W-1:0]     w_step;
    logic signed [16:0]     w_adj;
    logic signed [16:0]     w_quo_s;
    logic [SAMPLE_W-1:0]    w_wave_rd;
    logic [SAMPLE_W-1:0]    w_env_rd;

    assign w_count_eff = (r_count == '0) ? COUNT_W'(1) : r_count;
    assign w_rem2      = {r_rem, 1'b0};
    assign w_ge        = (w_rem2 >= {1'b0, w_count_eff});
    assign w_diff      = w_rem2 - {1'b0, w_count_eff};
    assign w_env_idx   = r_sat ? ENV_AW'(ENV_DEPTH - 1) : r_quo;

    assign w_in_note   = (i_in_data[20:16] > NOTE_LAST) ? NOTE_LAST : i_in_data[20:16];
    assign w_pidx      = (r_note >= NOTE_OCTUP) ? 4'(r_note - NOTE_OCTUP) : r_note[3:0];
    assign w_step_prod = STEP_PROD_W'(r_octave) * STEP_PROD_W'(pitch_step(w_pidx));
    assign w_step      = (r_note >= NOTE_OCTUP) ? r_step_prod[PHASE_W+2:3]
                                                : r_step_prod[PHASE_W+3:4];

    // Division by 128 rounds toward zero, so negative products are biased first.
    assign w_adj   = r_prod[16] ? (r_prod + 17'sd127) : r_prod;
    assign w_quo_s = w_adj >>> 7;

    wns_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WAVE_DEPTH)
    ) u_wave_ram (
        .i_clk   (i_clk),
        .i_we    (i_dp_cmd.wave_we),
        .i_waddr (i_in_data[WAVE_AW-1:0]),
        .i_wdata (i_in_data[15:8]),
        .i_re    (i_dp_cmd.mem_rd),
        .i_raddr (r_phase[PHASE_W-1:PHASE_W-WAVE_AW]),
        .o_rdata (w_wave_rd)
    );

    wns_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (ENV_DEPTH)
    ) u_env_ram (
        .i_clk   (i_clk),
        .i_we    (i_dp_cmd.env_we),
        .i_waddr (i_in_data[ENV_AW-1:0]),
        .i_wdata (i_in_data[15:8]),
        .i_re    (i_dp_cmd.mem_rd),
        .i_raddr (w_env_idx),
        .o_rdata (w_env_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octave    <= OCTAVE_W'(1);
            r_count     <= COUNT_W'(256);
            r_phase     <= '0;
            r_pos       <= '0;
            r_note      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg'(i_cfg_idx))
                    REG_OCTAVE_MULT:  r_octave <= i_cfg_data[OCTAVE_W-1:0];
                    REG_SAMPLE_COUNT: r_count  <= i_cfg_data[COUNT_W-1:0];
                    default:          r_octave <= r_octave;
                endcase
            end
            if (i_dp_cmd.note_start) begin
                r_note  <= w_in_note;
                r_phase <= '0;
                r_pos   <= '0;
            end else if (i_dp_cmd.out_load) begin
                if (r_last) begin
                    r_phase <= '0;
                    r_pos   <= '0;
                end else begin
                    r_phase <= r_phase + w_step;
                    r_pos   <= r_pos + 1'b1;
                end
            end
            if (i_dp_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.div_init) begin
            r_rem       <= r_pos;
            r_quo       <= '0;
            r_sat       <= (r_pos >= w_count_eff);
            r_last      <= ({1'b0, r_pos} + 1'b1 >= {1'b0, w_count_eff});
            r_step_prod <= w_step_prod;
        end else if (i_dp_cmd.div_step) begin
            r_rem <= w_ge ? w_diff[COUNT_W-1:0] : w_rem2[COUNT_W-1:0];
            r_quo <= {r_quo[ENV_AW-2:0], w_ge};
        end
        if (i_dp_cmd.mul_en) begin
            r_prod <= $signed(w_wave_rd) * $signed({1'b0, w_env_rd});
        end
        if (i_dp_cmd.out_load) begin
            r_sample   <= w_quo_s[SAMPLE_W-1:0] ^ 8'h80;
            r_out_last <= r_last;
        end
    end

    assign o_dp_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_sample          = r_sample;
    assign o_last            = r_out_last;

endmodule : wns_dpath
`default_nettype wire

### rtl/wavetable_note_synth.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wavetable_note_synth: wavetable oscillator with a volume envelope
// Builds the unsigned 8-bit samples of one note from a loaded wave table and
// envelope table, one sample for each emit request.
// ----------------------------------------------------------------------------
// Load and start requests take effect on acceptance. An emit request goes
// through accept, six steps of the radix-2 divider that finds the envelope
// index, a read of both tables, the multiply and the output load before its
// sample enters the output register. The output register lets the next
// request be accepted while a sample still waits to be taken; a further emit
// stalls at its output load until that register is free. The user must write
// configuration only while no request is in progress; it is not enforced.
module wavetable_note_synth (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [wns_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [wns_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // table_index [7:0], load_value [15:8], note_select [20:16], zero [23:21]
    input  wire logic [wns_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // command [1:0]
    input  wire logic [wns_pkg::CMD_W-1:0]           s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // sample_out [7:0]
    output logic [wns_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    output logic                                     m_axis_tlast
);
    import wns_pkg::*;

    t_dp_cmd w_dp_cmd;
    t_dp_sts w_dp_sts;

    wns_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_cmd    (s_axis_tuser),
        .o_ready  (s_axis_tready),
        .o_dp_cmd (w_dp_cmd),
        .i_dp_sts (w_dp_sts)
    );

    wns_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata[20:0]),
        .i_dp_cmd    (w_dp_cmd),
        .o_dp_sts    (w_dp_sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_sample    (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

endmodule : wavetable_note_synth
`default_nettype wire
